>>> rtl/core/amfs_pkg.sv
// ----------------------------------------------------------------------------
// Aging multilevel FIFO scheduler package
// Shared widths, operation and level codes, and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package amfs_pkg;

  localparam int DEFAULT_NUM_PROCS = 8;
  localparam int ID_W              = 3;
  localparam int OP_W              = 2;
  localparam int PRIO_W            = 2;
  localparam int NUM_LEVELS        = 3;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [PRIO_W-1:0] lvl_t;

  localparam op_t OP_SCHEDULE   = 2'd0;
  localparam op_t OP_SLOT_RESET = 2'd1;
  localparam op_t OP_CLEAR      = 2'd2;

  localparam lvl_t LVL_HIGH   = 2'd0;
  localparam lvl_t LVL_NORMAL = 2'd1;
  localparam lvl_t LVL_LOW    = 2'd2;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic age_high;
    logic age_normal;
    logic push_cur;
    logic select;
    logic compact;
    logic scan_last;
  } cmd_t;

  typedef struct packed {
    op_t                   op;
    logic [NUM_LEVELS-1:0] nonempty;
    logic                  scan_last;
  } status_t;

endpackage

>>> rtl/core/aging_multilevel_fifo_scheduler.sv
// ----------------------------------------------------------------------------
// Aging multilevel FIFO scheduler
// Three ready queues (high, normal, low) with aging on each schedule tick,
// slot removal with compaction, and clear.
//
// Channel   Signals                                          Handshake
// command   op, proc_id, proc_ready, proc_priority           start & !busy
// result    next_proc, went_idle, push_dropped               done, one cycle
//
// A schedule tick runs the two optional aging moves, each a read and a move
// through the queue memories, then the push and the selection.
// A slot reset sweeps every queue position for the removal, with one read
// and one write each, then the push.
// A clear, and the unused operation code, go straight to done.
// A new transaction is taken in the cycle after done. Reset is synchronous.
// ----------------------------------------------------------------------------
module aging_multilevel_fifo_scheduler
  import amfs_pkg::*;
#(
  parameter int NUM_PROCS = DEFAULT_NUM_PROCS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OP_W-1:0]   op,
  input  logic [ID_W-1:0]   proc_id,
  input  logic              proc_ready,
  input  logic [PRIO_W-1:0] proc_priority,
  output logic              busy,
  output logic              done,
  output logic [ID_W-1:0]   next_proc,
  output logic              went_idle,
  output logic              push_dropped
);

  cmd_t    cmd;
  status_t status;

  amfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  amfs_datapath #(
    .NUM_PROCS (NUM_PROCS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .op            (op),
    .proc_id       (proc_id),
    .proc_ready    (proc_ready),
    .proc_priority (proc_priority),
    .status        (status),
    .next_proc     (next_proc),
    .went_idle     (went_idle),
    .push_dropped  (push_dropped)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("Result strobe raised outside a transaction.");

  a_done_release: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("Busy held after the result was delivered.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not raise busy.");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (done && went_idle) |-> (next_proc == '0 && status.op == OP_SCHEDULE))
    else $error("Idle result with a process id or outside a schedule tick.");

endmodule

>>> rtl/core/amfs_ctrl.sv
// ----------------------------------------------------------------------------
// Aging multilevel FIFO scheduler controller
// Sequences the aging moves, the push, the selection and the compaction
// sweep for schedule ticks and slot resets, and the clear.
// ----------------------------------------------------------------------------
module amfs_ctrl
  import amfs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  op_t     op,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_AGE1_RD = 11'b00000000010,
    S_AGE1_MV = 11'b00000000100,
    S_AGE2_RD = 11'b00000001000,
    S_AGE2_MV = 11'b00000010000,
    S_PUSH    = 11'b00000100000,
    S_SEL_RD  = 11'b00001000000,
    S_SEL_POP = 11'b00010000000,
    S_RM_RD   = 11'b00100000000,
    S_RM_WR   = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (op)
            OP_SCHEDULE:   state_next = S_AGE1_RD;
            OP_SLOT_RESET: state_next = S_RM_RD;
            OP_CLEAR: begin
              cmd.clear  = 1'b1;
              state_next = S_DONE;
            end
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_AGE1_RD: begin
        state_next = status.nonempty[LVL_NORMAL] ? S_AGE1_MV : S_AGE2_RD;
      end
      S_AGE1_MV: begin
        cmd.age_high = 1'b1;
        state_next   = S_AGE2_RD;
      end
      S_AGE2_RD: begin
        state_next = status.nonempty[LVL_LOW] ? S_AGE2_MV : S_PUSH;
      end
      S_AGE2_MV: begin
        cmd.age_normal = 1'b1;
        state_next     = S_PUSH;
      end
      S_PUSH: begin
        cmd.push_cur = 1'b1;
        state_next   = (status.op == OP_SCHEDULE) ? S_SEL_RD : S_DONE;
      end
      S_SEL_RD: begin
        state_next = S_SEL_POP;
      end
      S_SEL_POP: begin
        cmd.select = 1'b1;
        state_next = S_DONE;
      end
      S_RM_RD: begin
        cmd.scan   = 1'b1;
        state_next = S_RM_WR;
      end
      S_RM_WR: begin
        cmd.compact = 1'b1;
        if (status.scan_last) begin
          cmd.scan_last = 1'b1;
          state_next    = S_PUSH;
        end else begin
          state_next = S_RM_RD;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

>>> rtl/core/amfs_datapath.sv
// ----------------------------------------------------------------------------
// Aging multilevel FIFO scheduler datapath
// Three circular ready queues held in memories, with head pointers, fill
// counts, the compaction counters and the result registers.
// ----------------------------------------------------------------------------
module amfs_datapath
  import amfs_pkg::*;
#(
  parameter int NUM_PROCS = DEFAULT_NUM_PROCS
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  op_t               op,
  input  logic [ID_W-1:0]   proc_id,
  input  logic              proc_ready,
  input  logic [PRIO_W-1:0] proc_priority,
  output status_t           status,
  output logic [ID_W-1:0]   next_proc,
  output logic              went_idle,
  output logic              push_dropped
);

  localparam int AW = $clog2(NUM_PROCS);
  localparam int CW = $clog2(NUM_PROCS + 1);
  localparam logic [CW-1:0] FULL = CW'(NUM_PROCS);
  localparam logic [AW:0]   WRAP = (AW + 1)'(NUM_PROCS);
  localparam logic [AW-1:0] LAST = AW'(NUM_PROCS - 1);

  typedef logic [AW-1:0]   ptr_t;
  typedef logic [CW-1:0]   cnt_t;
  typedef logic [ID_W-1:0] id_t;

  function automatic ptr_t wrap_add(ptr_t base, ptr_t offs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= WRAP) begin
      sum = sum - WRAP;
    end
    return sum[AW-1:0];
  endfunction

  op_t  cur_op;
  id_t  cur_id;
  lvl_t cur_lvl;
  logic cur_push;
  ptr_t scan_idx;

  ptr_t head    [NUM_LEVELS];
  cnt_t cnt     [NUM_LEVELS];
  cnt_t wr_cnt  [NUM_LEVELS];
  cnt_t wr_next [NUM_LEVELS];
  id_t  rd_data [NUM_LEVELS];

  logic [NUM_LEVELS-1:0] nonempty;
  logic [NUM_LEVELS-1:0] full;
  logic [NUM_LEVELS-1:0] pop;
  logic [NUM_LEVELS-1:0] push_hit;
  logic [NUM_LEVELS-1:0] push_ok;
  logic [NUM_LEVELS-1:0] keep;

  logic push_en;
  lvl_t push_lvl;
  id_t  push_data;
  lvl_t sel_lvl;
  logic push_drop;

  always_comb begin
    push_en   = 1'b0;
    push_lvl  = LVL_HIGH;
    push_data = cur_id;
    if (cmd.age_high) begin
      push_en   = 1'b1;
      push_lvl  = LVL_HIGH;
      push_data = rd_data[LVL_NORMAL];
    end else if (cmd.age_normal) begin
      push_en   = 1'b1;
      push_lvl  = LVL_NORMAL;
      push_data = rd_data[LVL_LOW];
    end else if (cmd.push_cur) begin
      push_en   = cur_push;
      push_lvl  = cur_lvl;
      push_data = cur_id;
    end
  end

  always_comb begin
    if (nonempty[LVL_HIGH]) begin
      sel_lvl = LVL_HIGH;
    end else if (nonempty[LVL_NORMAL]) begin
      sel_lvl = LVL_NORMAL;
    end else begin
      sel_lvl = LVL_LOW;
    end
  end

  assign push_drop = |(push_hit & full);

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
    id_t  mem [NUM_PROCS];
    ptr_t rd_addr;
    ptr_t wr_addr;
    id_t  wr_data;
    logic we;

    assign nonempty[g] = (cnt[g] != '0);
    assign full[g]     = (cnt[g] == FULL);
    assign push_hit[g] = push_en && (push_lvl == lvl_t'(g));
    assign push_ok[g]  = push_hit[g] && !full[g];
    assign pop[g]      = (cmd.age_high && (lvl_t'(g) == LVL_NORMAL))
                      || (cmd.age_normal && (lvl_t'(g) == LVL_LOW))
                      || (cmd.select && (|nonempty) && (sel_lvl == lvl_t'(g)));
    assign keep[g]     = cmd.compact && (cnt_t'(scan_idx) < cnt[g])
                      && (rd_data[g] != cur_id);
    assign wr_next[g]  = wr_cnt[g] + cnt_t'(keep[g]);

    assign rd_addr = cmd.scan ? wrap_add(head[g], scan_idx) : head[g];
    assign we      = push_ok[g] || keep[g];
    assign wr_addr = keep[g] ? wrap_add(head[g], wr_cnt[g][AW-1:0])
                             : wrap_add(head[g], cnt[g][AW-1:0]);
    assign wr_data = keep[g] ? rd_data[g] : push_data;

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wr_addr] <= wr_data;
      end
      rd_data[g] <= mem[rd_addr];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        head[g] <= '0;
        cnt[g]  <= '0;
      end else begin
        if (cmd.clear) begin
          cnt[g] <= '0;
        end else if (cmd.scan_last) begin
          cnt[g] <= wr_next[g];
        end else if (push_ok[g]) begin
          cnt[g] <= cnt[g] + cnt_t'(1);
        end else if (pop[g]) begin
          cnt[g] <= cnt[g] - cnt_t'(1);
        end
        if (pop[g]) begin
          head[g] <= wrap_add(head[g], ptr_t'(1));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        wr_cnt[g] <= '0;
      end else if (keep[g]) begin
        wr_cnt[g] <= wr_next[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_op <= OP_SCHEDULE;
    end else if (cmd.load) begin
      cur_op <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_id       <= proc_id;
      cur_lvl      <= (proc_priority >= LVL_LOW) ? LVL_LOW : proc_priority;
      cur_push     <= (proc_id != '0) && proc_ready;
      scan_idx     <= '0;
      next_proc    <= '0;
      went_idle    <= 1'b0;
      push_dropped <= 1'b0;
    end else begin
      if (cmd.compact && !cmd.scan_last) begin
        scan_idx <= scan_idx + ptr_t'(1);
      end
      if (push_drop) begin
        push_dropped <= 1'b1;
      end
      if (cmd.select) begin
        if (|nonempty) begin
          next_proc <= rd_data[sel_lvl];
        end else begin
          went_idle <= 1'b1;
        end
      end
    end
  end

  assign status.op        = cur_op;
  assign status.nonempty  = nonempty;
  assign status.scan_last = (scan_idx == LAST);

endmodule
